FILE: hw/rtl/tmo_pkg.sv
// ----------------------------------------------------------------------------
// tmo_pkg
// Shared widths, constants and the sine table for the omni wheel mixer.
// ----------------------------------------------------------------------------
`default_nettype none

package tmo_pkg;

  localparam int DUTY_FRACTION_BITS = 10;
  localparam int DW   = DUTY_FRACTION_BITS + 1;
  localparam logic [DW-1:0] DUTY_FULL = DW'(1) << DUTY_FRACTION_BITS;

  localparam int HW   = 9;
  localparam int PW   = 7;
  localparam int CW   = 8;
  localparam int SW   = 15;
  localparam int MW   = 14;
  localparam int PMW  = 20;
  localparam int DENW = 20;
  localparam int NW   = PMW + DUTY_FRACTION_BITS + 1;
  localparam int NUM_WHEELS = 3;

  localparam logic [HW-1:0] HEADING_MOD = 9'd360;
  localparam logic [PW-1:0] POWER_MAX   = 7'd100;
  localparam logic signed [CW-1:0] CORR_MAX = 8'sd100;
  localparam logic signed [15:0]   SINE_ONE = 16'sd10000;
  localparam logic signed [15:0]   CORR_SCALE = 16'sd100;
  localparam logic [DENW-1:0]      PCT_DEN = 20'd100;

  localparam logic [HW-1:0] WHEEL_OFFSET [0:NUM_WHEELS-1] = '{9'd60, 9'd180, 9'd300};

  localparam logic [MW-1:0] SINE_Q [0:90] = '{
    14'd0, 14'd175, 14'd349, 14'd523, 14'd698, 14'd872, 14'd1045, 14'd1219, 14'd1392,
    14'd1564, 14'd1736, 14'd1908, 14'd2079, 14'd2250, 14'd2419, 14'd2588, 14'd2756,
    14'd2924, 14'd3090, 14'd3256, 14'd3420, 14'd3584, 14'd3746, 14'd3907, 14'd4067,
    14'd4226, 14'd4384, 14'd4540, 14'd4695, 14'd4848, 14'd5000, 14'd5150, 14'd5299,
    14'd5446, 14'd5592, 14'd5736, 14'd5878, 14'd6018, 14'd6157, 14'd6293, 14'd6428,
    14'd6561, 14'd6691, 14'd6820, 14'd6947, 14'd7071, 14'd7193, 14'd7314, 14'd7431,
    14'd7547, 14'd7660, 14'd7771, 14'd7880, 14'd7986, 14'd8090, 14'd8192, 14'd8290,
    14'd8387, 14'd8480, 14'd8572, 14'd8660, 14'd8746, 14'd8829, 14'd8910, 14'd8988,
    14'd9063, 14'd9135, 14'd9205, 14'd9272, 14'd9336, 14'd9397, 14'd9455, 14'd9511,
    14'd9563, 14'd9613, 14'd9659, 14'd9703, 14'd9744, 14'd9781, 14'd9816, 14'd9848,
    14'd9877, 14'd9903, 14'd9925, 14'd9945, 14'd9962, 14'd9976, 14'd9986, 14'd9994,
    14'd9998, 14'd10000
  };

  typedef struct packed {
    logic [NW-1:0] rem;
    logic [DW-1:0] q;
    logic          neg;
    logic          nz;
  } lane_t;

  // angle 0..359, result in units of 1/10000
  function automatic logic signed [15:0] sine_deg(input logic [HW-1:0] a);
    logic [6:0]    idx;
    logic          neg;
    if (a <= 9'd90) begin
      idx = a[6:0];
      neg = 1'b0;
    end else if (a <= 9'd180) begin
      idx = 7'(9'd180 - a);
      neg = 1'b0;
    end else if (a <= 9'd270) begin
      idx = 7'(a - 9'd180);
      neg = 1'b1;
    end else begin
      idx = 7'(9'd360 - a);
      neg = 1'b1;
    end
    sine_deg = neg ? -$signed({2'b00, SINE_Q[idx]}) : $signed({2'b00, SINE_Q[idx]});
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/three_wheel_omni_mixer_unit.sv
// ----------------------------------------------------------------------------
// three_wheel_omni_mixer_unit
// Heading, power and spin correction to H-bridge duties for three wheels.
// ----------------------------------------------------------------------------
// Input channel in_*: heading_deg, drive_power, spin_correction, taken when
// in_valid is high and in_stall is low. Output channel out_*: forward and
// reverse duty for wheels a, b and c as fractions of 2^DUTY_FRACTION_BITS.
// One item enters per cycle and one result leaves per cycle while out_stall
// does not hold the pipeline. The stages in order: angle, sine, magnitude
// and product work, forming the dividend, a divider stage for each
// quotient bit of the restoring divider, and the output register.
// The whole pipeline advances together; while out_valid is high and
// out_stall is high every stage holds and in_stall is raised, so no item
// is dropped or repeated. Bubbles travel as cleared valid bits.
// Synchronous active-low reset clears all valid bits; payload registers are
// not reset and the block is ready in the first cycle after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module three_wheel_omni_mixer_unit (
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic [tmo_pkg::HW-1:0]   in_heading_deg,
  input  wire logic [tmo_pkg::PW-1:0]   in_drive_power,
  input  wire logic signed [tmo_pkg::CW-1:0] in_spin_correction,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic [tmo_pkg::DW-1:0]        out_wheel_a_forward_duty,
  output logic [tmo_pkg::DW-1:0]        out_wheel_a_reverse_duty,
  output logic [tmo_pkg::DW-1:0]        out_wheel_b_forward_duty,
  output logic [tmo_pkg::DW-1:0]        out_wheel_b_reverse_duty,
  output logic [tmo_pkg::DW-1:0]        out_wheel_c_forward_duty,
  output logic [tmo_pkg::DW-1:0]        out_wheel_c_reverse_duty
);

  localparam int NWH = tmo_pkg::NUM_WHEELS;
  localparam int DW  = tmo_pkg::DW;
  localparam int HW_EXT = tmo_pkg::HW + 1;

  logic adv;

  // stage 1
  logic                          v1_r;
  logic [tmo_pkg::HW-1:0]        ang1_r [0:NWH-1];
  logic [tmo_pkg::PW-1:0]        pow1_r;
  logic signed [tmo_pkg::CW-1:0] corr1_r;
  logic [tmo_pkg::HW-1:0]        ang1_nxt [0:NWH-1];
  logic [tmo_pkg::PW-1:0]        pow1_nxt;
  logic signed [tmo_pkg::CW-1:0] corr1_nxt;
  logic [tmo_pkg::HW-1:0]        head_m;

  // stage 2
  logic                          v2_r;
  logic signed [tmo_pkg::SW-1:0] val2_r [0:NWH-1];
  logic [tmo_pkg::PW-1:0]        pow2_r;
  logic signed [tmo_pkg::CW-1:0] corr2_r;
  logic signed [tmo_pkg::SW-1:0] val2_nxt [0:NWH-1];

  // stage 3
  logic                          v3_r;
  logic [tmo_pkg::MW-1:0]        mag3_r [0:NWH-1];
  logic                          neg3_r [0:NWH-1];
  logic                          nz3_r [0:NWH-1];
  logic [tmo_pkg::MW-1:0]        maxm3_r;
  logic [tmo_pkg::PW-1:0]        pow3_r;
  logic [tmo_pkg::MW-1:0]        mag3_nxt [0:NWH-1];
  logic                          neg3_nxt [0:NWH-1];
  logic                          nz3_nxt [0:NWH-1];
  logic [tmo_pkg::MW-1:0]        maxm3_nxt;
  logic [tmo_pkg::MW-1:0]        vmag [0:NWH-1];
  logic [tmo_pkg::CW-1:0]        cabs;
  logic [tmo_pkg::MW-1:0]        cmag;

  // stage 4
  logic                          v4_r;
  logic [tmo_pkg::PMW-1:0]       pm4_r [0:NWH-1];
  logic                          neg4_r [0:NWH-1];
  logic                          nz4_r [0:NWH-1];
  logic [tmo_pkg::DENW-1:0]      den4_r;

  // divider stages, index 0 holds the dividend
  logic                          dv_r  [0:DW];
  logic [tmo_pkg::DENW-1:0]      den_r [0:DW];
  tmo_pkg::lane_t                lane_r [0:DW][0:NWH-1];

  // output
  logic                          out_valid_r;
  logic [DW-1:0]                 fwd_r [0:NWH-1];
  logic [DW-1:0]                 rev_r [0:NWH-1];

  assign adv      = !(out_valid_r && out_stall);
  assign in_stall = !adv;

  // heading reduction, angle per wheel, input saturation
  always_comb begin
    logic [HW_EXT-1:0] t;
    head_m = (in_heading_deg >= tmo_pkg::HEADING_MOD) ?
             in_heading_deg - tmo_pkg::HEADING_MOD : in_heading_deg;
    for (int w = 0; w < NWH; w++) begin
      t = {1'b0, head_m} + {1'b0, tmo_pkg::HEADING_MOD - tmo_pkg::WHEEL_OFFSET[w]};
      ang1_nxt[w] = (t >= {1'b0, tmo_pkg::HEADING_MOD}) ?
                    tmo_pkg::HW'(t - {1'b0, tmo_pkg::HEADING_MOD}) : tmo_pkg::HW'(t);
    end
    pow1_nxt = (in_drive_power > tmo_pkg::POWER_MAX) ? tmo_pkg::POWER_MAX : in_drive_power;
    if (in_spin_correction > tmo_pkg::CORR_MAX) begin
      corr1_nxt = tmo_pkg::CORR_MAX;
    end else if (in_spin_correction < -tmo_pkg::CORR_MAX) begin
      corr1_nxt = -tmo_pkg::CORR_MAX;
    end else begin
      corr1_nxt = in_spin_correction;
    end
  end

  // sine plus correction, clamped
  always_comb begin
    logic signed [15:0] s;
    logic signed [15:0] cs;
    cs = 16'({{8{corr1_r[7]}}, corr1_r}) * tmo_pkg::CORR_SCALE;
    for (int w = 0; w < NWH; w++) begin
      s = tmo_pkg::sine_deg(ang1_r[w]) + cs;
      if (s > tmo_pkg::SINE_ONE) begin
        s = tmo_pkg::SINE_ONE;
      end else if (s < -tmo_pkg::SINE_ONE) begin
        s = -tmo_pkg::SINE_ONE;
      end
      val2_nxt[w] = tmo_pkg::SW'(s);
    end
  end

  // magnitudes and the largest one; zero power uses the correction alone
  always_comb begin
    cabs = corr2_r[7] ? tmo_pkg::CW'(-corr2_r) : tmo_pkg::CW'(corr2_r);
    cmag = tmo_pkg::MW'(cabs);
    for (int w = 0; w < NWH; w++) begin
      vmag[w] = val2_r[w][tmo_pkg::SW-1] ? tmo_pkg::MW'(-val2_r[w]) : tmo_pkg::MW'(val2_r[w]);
    end
    maxm3_nxt = (vmag[0] > vmag[1]) ? vmag[0] : vmag[1];
    maxm3_nxt = (vmag[2] > maxm3_nxt) ? vmag[2] : maxm3_nxt;
    for (int w = 0; w < NWH; w++) begin
      if (pow2_r == '0) begin
        mag3_nxt[w] = cmag;
        neg3_nxt[w] = corr2_r[7];
        nz3_nxt[w]  = corr2_r != '0;
      end else begin
        mag3_nxt[w] = vmag[w];
        neg3_nxt[w] = val2_r[w][tmo_pkg::SW-1];
        nz3_nxt[w]  = val2_r[w] != '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      v3_r        <= 1'b0;
      v4_r        <= 1'b0;
      dv_r[0]     <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      v1_r        <= in_valid;
      v2_r        <= v1_r;
      v3_r        <= v2_r;
      v4_r        <= v3_r;
      dv_r[0]     <= v4_r;
      out_valid_r <= dv_r[DW];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ang1_r  <= ang1_nxt;
      pow1_r  <= pow1_nxt;
      corr1_r <= corr1_nxt;

      val2_r  <= val2_nxt;
      pow2_r  <= pow1_r;
      corr2_r <= corr1_r;

      mag3_r  <= mag3_nxt;
      neg3_r  <= neg3_nxt;
      nz3_r   <= nz3_nxt;
      maxm3_r <= maxm3_nxt;
      pow3_r  <= pow2_r;

      den4_r <= (pow3_r == '0) ? tmo_pkg::PCT_DEN :
                tmo_pkg::DENW'(tmo_pkg::DENW'(maxm3_r) * tmo_pkg::PCT_DEN);
      for (int w = 0; w < NWH; w++) begin
        pm4_r[w]  <= (pow3_r == '0) ? tmo_pkg::PMW'(mag3_r[w]) :
                     tmo_pkg::PMW'(tmo_pkg::PMW'(pow3_r) * tmo_pkg::PMW'(mag3_r[w]));
        neg4_r[w] <= neg3_r[w];
        nz4_r[w]  <= nz3_r[w];
      end

      // dividend with half the divisor added for round half up
      den_r[0] <= den4_r;
      for (int w = 0; w < NWH; w++) begin
        lane_r[0][w].rem <= {1'b0, pm4_r[w], tmo_pkg::DUTY_FRACTION_BITS'(0)} +
                            tmo_pkg::NW'(den4_r >> 1);
        lane_r[0][w].q   <= '0;
        lane_r[0][w].neg <= neg4_r[w];
        lane_r[0][w].nz  <= nz4_r[w];
      end

      for (int w = 0; w < NWH; w++) begin
        if (!lane_r[DW][w].nz) begin
          fwd_r[w] <= tmo_pkg::DUTY_FULL;
          rev_r[w] <= tmo_pkg::DUTY_FULL;
        end else if (lane_r[DW][w].neg) begin
          fwd_r[w] <= '0;
          rev_r[w] <= lane_r[DW][w].q;
        end else begin
          fwd_r[w] <= lane_r[DW][w].q;
          rev_r[w] <= '0;
        end
      end
    end
  end

  // restoring divider, one quotient bit per stage, msb first
  for (genvar k = 0; k < DW; k++) begin : g_div
    logic [tmo_pkg::NW-1:0] trial;
    tmo_pkg::lane_t         lane_nxt [0:NWH-1];
    assign trial = tmo_pkg::NW'(den_r[k]) << (DW - 1 - k);

    always_comb begin
      for (int w = 0; w < NWH; w++) begin
        lane_nxt[w] = lane_r[k][w];
        if (lane_r[k][w].rem >= trial) begin
          lane_nxt[w].rem = lane_r[k][w].rem - trial;
          lane_nxt[w].q[DW-1-k] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        dv_r[k+1] <= 1'b0;
      end else if (adv) begin
        dv_r[k+1] <= dv_r[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        den_r[k+1] <= den_r[k];
        for (int w = 0; w < NWH; w++) begin
          lane_r[k+1][w] <= lane_nxt[w];
        end
      end
    end
  end

  assign out_valid                = out_valid_r;
  assign out_wheel_a_forward_duty = fwd_r[0];
  assign out_wheel_a_reverse_duty = rev_r[0];
  assign out_wheel_b_forward_duty = fwd_r[1];
  assign out_wheel_b_reverse_duty = rev_r[1];
  assign out_wheel_c_forward_duty = fwd_r[2];
  assign out_wheel_c_reverse_duty = rev_r[2];

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (fwd_r[0] <= tmo_pkg::DUTY_FULL && rev_r[0] <= tmo_pkg::DUTY_FULL &&
                     fwd_r[1] <= tmo_pkg::DUTY_FULL && rev_r[1] <= tmo_pkg::DUTY_FULL &&
                     fwd_r[2] <= tmo_pkg::DUTY_FULL && rev_r[2] <= tmo_pkg::DUTY_FULL))
    else $error("duty above full scale");

  a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && fwd_r[0] != '0 && rev_r[0] != '0) |->
      (fwd_r[0] == tmo_pkg::DUTY_FULL && rev_r[0] == tmo_pkg::DUTY_FULL))
    else $error("wheel a driven both ways without brake");

  a_div_rem: assert property (@(posedge clk) disable iff (!rst_n)
    (dv_r[DW] && lane_r[DW][0].nz && den_r[DW] != '0) |->
      lane_r[DW][0].rem < tmo_pkg::NW'(den_r[DW]))
    else $error("divider remainder not below divisor");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> ($stable(lane_r[DW][0]) && $stable(dv_r[DW])))
    else $error("pipeline moved while stalled");
`endif

endmodule

`default_nettype wire

FILE: bench/three_wheel_omni_mixer_unit_tb.sv
// ----------------------------------------------------------------------------
// three_wheel_omni_mixer_unit_tb
// Self-checking bench for the omni wheel mixer: a queue-fed driver offers
// items in random bursts, a monitor stalls on its own pattern (with one long
// hold-off) and compares each result with a local duty predictor.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module three_wheel_omni_mixer_unit_tb;

  typedef struct packed {
    logic [tmo_pkg::HW-1:0]        heading;
    logic [tmo_pkg::PW-1:0]        power;
    logic signed [tmo_pkg::CW-1:0] corr;
  } cmd_t;

  typedef struct packed {
    logic [tmo_pkg::DW-1:0] af, ar, bf, br, cf, cr;
  } duty_t;

  localparam int LAT = tmo_pkg::DUTY_FRACTION_BITS + 7;
  localparam int NUM_RANDOM = 1900;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [tmo_pkg::HW-1:0] in_heading_deg = '0;
  logic [tmo_pkg::PW-1:0] in_drive_power = '0;
  logic signed [tmo_pkg::CW-1:0] in_spin_correction = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [tmo_pkg::DW-1:0] out_af, out_ar, out_bf, out_br, out_cf, out_cr;

  cmd_t  pending_cmds[$];
  duty_t expected_duties[$];
  int    fail_count = 0;
  bit    stim_done = 0;
  int    burst_left = 0;
  int    gap_left = 0;
  int    stall_mode_cycles = 0;
  int    hold_cycles = 0;
  bit    hold_done = 0;
  int    accepted = 0;

  three_wheel_omni_mixer_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_heading_deg(in_heading_deg), .in_drive_power(in_drive_power),
    .in_spin_correction(in_spin_correction),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_wheel_a_forward_duty(out_af), .out_wheel_a_reverse_duty(out_ar),
    .out_wheel_b_forward_duty(out_bf), .out_wheel_b_reverse_duty(out_br),
    .out_wheel_c_forward_duty(out_cf), .out_wheel_c_reverse_duty(out_cr)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic int table_sine(int a);
    if (a <= 90) return int'(tmo_pkg::SINE_Q[a]);
    if (a <= 180) return int'(tmo_pkg::SINE_Q[180 - a]);
    if (a <= 270) return -int'(tmo_pkg::SINE_Q[a - 180]);
    return -int'(tmo_pkg::SINE_Q[360 - a]);
  endfunction

  function automatic void wheel_duty(int sign, longint duty,
                                     output logic [tmo_pkg::DW-1:0] fwd,
                                     output logic [tmo_pkg::DW-1:0] rev);
    longint full;
    full = longint'(1) << tmo_pkg::DUTY_FRACTION_BITS;
    if (sign == 0) begin
      fwd = tmo_pkg::DW'(full);
      rev = tmo_pkg::DW'(full);
    end else if (sign > 0) begin
      fwd = tmo_pkg::DW'(duty);
      rev = '0;
    end else begin
      fwd = '0;
      rev = tmo_pkg::DW'(duty);
    end
  endfunction

  function automatic duty_t mix_duties(cmd_t c);
    duty_t r;
    int heading, power, corr, maxmag, s;
    int v[3];
    int mag[3];
    int offs[3];
    longint full, duty, num, den;
    logic [tmo_pkg::DW-1:0] f[3];
    logic [tmo_pkg::DW-1:0] b[3];
    offs = '{60, 180, 300};
    full = longint'(1) << tmo_pkg::DUTY_FRACTION_BITS;
    heading = int'(c.heading) % 360;
    power = int'(c.power);
    corr = int'($signed(c.corr));
    maxmag = 0;
    if (power > 100) power = 100;
    if (corr > 100) corr = 100;
    if (corr < -100) corr = -100;
    if (power == 0) begin
      duty = ((corr < 0 ? -corr : corr) * full + 50) / 100;
      for (int w = 0; w < 3; w++) wheel_duty(corr, duty, f[w], b[w]);
    end else begin
      for (int w = 0; w < 3; w++) begin
        s = table_sine((heading + 360 - offs[w]) % 360) + corr * 100;
        if (s > 10000) s = 10000;
        if (s < -10000) s = -10000;
        v[w] = s;
        mag[w] = s < 0 ? -s : s;
        if (mag[w] > maxmag) maxmag = mag[w];
      end
      for (int w = 0; w < 3; w++) begin
        if (maxmag == 0) begin
          wheel_duty(0, 0, f[w], b[w]);
        end else begin
          num = longint'(power) * mag[w] * full;
          den = longint'(100) * maxmag;
          wheel_duty(v[w], (num + den / 2) / den, f[w], b[w]);
        end
      end
    end
    r.af = f[0]; r.ar = b[0]; r.bf = f[1]; r.br = b[1]; r.cf = f[2]; r.cr = b[2];
    return r;
  endfunction

  function automatic cmd_t make_cmd(int h, int p, int c);
    cmd_t x;
    x.heading = tmo_pkg::HW'(h);
    x.power = tmo_pkg::PW'(p);
    x.corr = tmo_pkg::CW'(c);
    return x;
  endfunction

  initial begin
    int hd[8];
    hd = '{0, 60, 90, 180, 240, 300, 359, 150};
    foreach (hd[i]) pending_cmds.push_back(make_cmd(hd[i], 100, 0));
    pending_cmds.push_back(make_cmd(0, 0, 0));
    pending_cmds.push_back(make_cmd(0, 0, 100));
    pending_cmds.push_back(make_cmd(0, 0, -100));
    pending_cmds.push_back(make_cmd(0, 0, 1));
    pending_cmds.push_back(make_cmd(0, 0, 127));
    pending_cmds.push_back(make_cmd(0, 0, -128));
    pending_cmds.push_back(make_cmd(511, 127, 127));
    pending_cmds.push_back(make_cmd(360, 1, -128));
    pending_cmds.push_back(make_cmd(300, 1, 0));
    pending_cmds.push_back(make_cmd(45, 50, 100));
    pending_cmds.push_back(make_cmd(200, 100, -100));
    pending_cmds.push_back(make_cmd(90, 100, -50));
    pending_cmds.push_back(make_cmd(480, 100, 30));
    for (int i = 0; i < NUM_RANDOM; i++) begin
      if ($urandom_range(0, 9) == 0)
        pending_cmds.push_back(make_cmd($urandom_range(0, 511), $urandom_range(0, 127),
                                        $signed(8'($urandom))));
      else
        pending_cmds.push_back(make_cmd($urandom_range(0, 359),
                                        $urandom_range(0, 4) == 0 ? 0 : $urandom_range(1, 100),
                                        $urandom_range(0, 200) - 100));
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        expected_duties.push_back(mix_duties(pending_cmds.pop_front()));
        accepted++;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left > 0) gap_left--;
        if (pending_cmds.size() == 0) begin
          in_valid <= 1'b0;
          stim_done <= 1'b1;
        end else if (gap_left > 0) begin
          in_valid <= 1'b0;
        end else begin
          in_valid <= 1'b1;
          in_heading_deg <= pending_cmds[0].heading;
          in_drive_power <= pending_cmds[0].power;
          in_spin_correction <= pending_cmds[0].corr;
          if (burst_left > 0) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 40);
            gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
          end
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    duty_t e;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_duties.size() == 0) begin
          $error("unexpected result item");
          fail_count++;
        end else begin
          e = expected_duties.pop_front();
          if (out_af !== e.af) begin
            $error("wheel_a_forward_duty exp %0d got %0d", e.af, out_af); fail_count++;
          end
          if (out_ar !== e.ar) begin
            $error("wheel_a_reverse_duty exp %0d got %0d", e.ar, out_ar); fail_count++;
          end
          if (out_bf !== e.bf) begin
            $error("wheel_b_forward_duty exp %0d got %0d", e.bf, out_bf); fail_count++;
          end
          if (out_br !== e.br) begin
            $error("wheel_b_reverse_duty exp %0d got %0d", e.br, out_br); fail_count++;
          end
          if (out_cf !== e.cf) begin
            $error("wheel_c_forward_duty exp %0d got %0d", e.cf, out_cf); fail_count++;
          end
          if (out_cr !== e.cr) begin
            $error("wheel_c_reverse_duty exp %0d got %0d", e.cr, out_cr); fail_count++;
          end
        end
      end
      // long hold-off once the pipe is busy
      if (!hold_done && accepted > 300) begin
        hold_cycles++;
        out_stall <= 1'b1;
        if (hold_cycles >= 200) hold_done = 1;
      end else begin
        if (stall_mode_cycles > 0) stall_mode_cycles--;
        else stall_mode_cycles = $urandom_range(1, 60);
        case ((accepted / 150) % 3)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          default: out_stall <= (stall_mode_cycles % 7 < 3);
        endcase
      end
    end
  end

  initial begin
    @(posedge rst_n);
    wait (stim_done);
    while (expected_duties.size() != 0) @(posedge clk);
    repeat (LAT + 5) @(posedge clk);
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

`default_nettype wire
